FILE: hdl/chb_pkg.sv
package chb_pkg;

	typedef logic [3:0][63:0] chain_t;

	typedef struct packed {
		logic       we;
		logic [4:0] pos;
		logic [7:0] data;
	} buf_wr_t;

	localparam chain_t CHAIN_INIT = {
		64'h7158932402138901,
		64'h32A398246E20349A,
		64'h8A59B51F41029312,
		64'hD6D12E7B5A03A401
	};

	localparam int unsigned ROT0 = 19;
	localparam int unsigned ROT1 = 29;
	localparam int unsigned ROT2 = 37;
	localparam int unsigned ROT3 = 43;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [4:0] LEN_POS  = 5'd24;
	localparam logic [4:0] LAST_POS = 5'd31;
	localparam logic [4:0] LAST_STEP = 5'd31;

	localparam logic [7:0] PRIME_PAD [32] = '{
		8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,
		8'd23,  8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,
		8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,
		8'd97,  8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131
	};

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
		rotl64 = (v << s) | (v >> (64 - s));
	endfunction

endpackage

FILE: hdl/chb_mix.sv
// one half round per call: first half updates words 0..2, second half word 3 and the xor fold
module chb_mix (
	input  chb_pkg::chain_t c,
	input  chb_pkg::chain_t m,
	input  logic            half,
	output chb_pkg::chain_t n
);

	logic [63:0] w3;

	assign w3 = chb_pkg::rotl64(c[3] ^ m[3], chb_pkg::ROT3) + c[0];

	always_comb begin
		if (!half) begin
			n[0] = chb_pkg::rotl64(c[0] ^ m[0], chb_pkg::ROT0) + c[1];
			n[1] = chb_pkg::rotl64(c[1] ^ m[1], chb_pkg::ROT1) + c[2];
			n[2] = chb_pkg::rotl64(c[2] ^ m[2], chb_pkg::ROT2) + c[3];
			n[3] = c[3];
		end else begin
			n[0] = c[0] ^ c[2];
			n[1] = c[1] ^ w3;
			n[2] = c[2];
			n[3] = w3;
		end
	end

endmodule

FILE: hdl/chb_blkbuf.sv
// 32-byte block store; presents four big-endian words, byte-reversed while reverse is high
module chb_blkbuf (
	input  logic             clk,
	input  chb_pkg::buf_wr_t wr,
	input  logic             reverse,
	output chb_pkg::chain_t  m
);

	logic [7:0] buf_q [32];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			buf_q[wr.pos] <= wr.data;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 8; i++) begin
				if (reverse) begin
					m[k][8*(7-i) +: 8] = buf_q[5'(31 - (k*8 + i))];
				end else begin
					m[k][8*(7-i) +: 8] = buf_q[5'(k*8 + i)];
				end
			end
		end
	end

endmodule

FILE: hdl/custom_block_hash_256_core.sv
// Byte-serial block hash with a 256-bit digest.
// Request channel (req_valid/req_stall): one message byte per request with
// has_byte and last flags; has_byte=0 with last=1 ends a message with no byte.
// Digest channel (dig_valid/dig_stall): four 64-bit words, word_index 0..3,
// last_word set on the fourth.
// Each absorbed byte is stored in the block buffer. A full 32-byte block
// is compressed in 16 rounds, two half-round steps each, through the one
// shared mixing unit. On last, padding writes one byte per cycle (9 to 40
// bytes, one or two more blocks), then the four digest words follow, one per
// cycle while the receiver does not stall.
// req_stall is high whenever the block is compressing, padding or emitting.
// A stall on the digest channel holds the current word and the block waits.
// Reset (arst_n low) loads the initial chaining words, clears the byte count
// and the block parity; the same happens after the fourth word is taken.
module custom_block_hash_256_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_EMIT
	} state_t;

	state_t           state_q;
	chb_pkg::chain_t  chain_q;
	chb_pkg::chain_t  mix_n;
	chb_pkg::chain_t  msg;
	chb_pkg::buf_wr_t wr;
	logic [63:0]      count_q;
	logic [4:0]       pos_q;
	logic [4:0]       step_q;
	logic             parity_q;
	logic             pad_q;
	logic             mark_q;
	logic             len_q;
	logic [1:0]       idx_q;
	logic [7:0]       pad_byte;
	logic [7:0]       len_byte;

	chb_blkbuf u_buf (
		.clk     (clk),
		.wr      (wr),
		.reverse (parity_q),
		.m       (msg)
	);

	chb_mix u_mix (
		.c    (chain_q),
		.m    (msg),
		.half (step_q[0]),
		.n    (mix_n)
	);

	// byte count goes out big-endian in positions 24..31
	assign len_byte = 8'(count_q >> {~pos_q[2:0], 3'b000});

	always_comb begin
		if (!mark_q) begin
			pad_byte = chb_pkg::PAD_MARK;
		end else if (len_q || pos_q == chb_pkg::LEN_POS) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = chb_pkg::PRIME_PAD[pos_q];
		end
	end

	always_comb begin
		wr.pos = pos_q;
		if (state_q == ST_PAD) begin
			wr.we   = 1'b1;
			wr.data = pad_byte;
		end else begin
			wr.we   = state_q == ST_IDLE && req_valid && has_byte;
			wr.data = data_byte;
		end
	end

	assign req_stall   = state_q != ST_IDLE;
	assign dig_valid   = state_q == ST_EMIT;
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = &idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chain_q  <= chb_pkg::CHAIN_INIT;
			count_q  <= '0;
			pos_q    <= '0;
			step_q   <= '0;
			parity_q <= 1'b0;
			pad_q    <= 1'b0;
			mark_q   <= 1'b0;
			len_q    <= 1'b0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (has_byte) begin
							count_q <= count_q + 64'd1;
							pos_q   <= pos_q + 5'd1;
							if (pos_q == chb_pkg::LAST_POS) begin
								state_q <= ST_COMP;
								pad_q   <= last;
							end else if (last) begin
								state_q <= ST_PAD;
								pad_q   <= 1'b1;
							end
						end else if (last) begin
							state_q <= ST_PAD;
							pad_q   <= 1'b1;
						end
					end
				end
				ST_COMP: begin
					chain_q <= mix_n;
					step_q  <= step_q + 5'd1;
					if (step_q == chb_pkg::LAST_STEP) begin
						parity_q <= ~parity_q;
						if (len_q) begin
							state_q <= ST_EMIT;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					pos_q  <= pos_q + 5'd1;
					mark_q <= 1'b1;
					if (mark_q && pos_q == chb_pkg::LEN_POS) begin
						len_q <= 1'b1;
					end
					if (pos_q == chb_pkg::LAST_POS) begin
						state_q <= ST_COMP;
					end
				end
				ST_EMIT: begin
					if (!dig_stall) begin
						idx_q <= idx_q + 2'd1;
						if (&idx_q) begin
							state_q  <= ST_IDLE;
							chain_q  <= chb_pkg::CHAIN_INIT;
							count_q  <= '0;
							pos_q    <= '0;
							parity_q <= 1'b0;
							pad_q    <= 1'b0;
							mark_q   <= 1'b0;
							len_q    <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
